[sv/owbm_pkg.sv]
// Package with the types, codes and timing table of the one-wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

  // Command codes carried by an input transaction. They double as the
  // operation code held while an operation runs.
  localparam logic [2:0] CMD_TICK       = 3'd0;
  localparam logic [2:0] CMD_RESET      = 3'd1;
  localparam logic [2:0] CMD_WRITE_BIT  = 3'd2;
  localparam logic [2:0] CMD_READ_BIT   = 3'd3;
  localparam logic [2:0] CMD_WRITE_BYTE = 3'd4;
  localparam logic [2:0] CMD_READ_BYTE  = 3'd5;

  localparam int unsigned CNT_W = 9;
  localparam logic [1:0] SPEED_RESET = 2'd0;

  typedef enum logic [2:0] {
    OP_IDLE       = 3'd0,
    OP_RESET      = 3'd1,
    OP_WRITE_BIT  = 3'd2,
    OP_READ_BIT   = 3'd3,
    OP_WRITE_BYTE = 3'd4,
    OP_READ_BYTE  = 3'd5
  } op_t;

  // Phase lengths of a slot; the letters follow the usual bus timing names.
  typedef enum logic [3:0] {
    TM_A = 4'd0,
    TM_B = 4'd1,
    TM_C = 4'd2,
    TM_D = 4'd3,
    TM_E = 4'd4,
    TM_F = 4'd5,
    TM_H = 4'd6,
    TM_I = 4'd7,
    TM_J = 4'd8
  } tm_t;

  localparam logic [CNT_W-1:0] TIMING [4][9] = '{
    '{9'd6, 9'd64, 9'd60, 9'd10, 9'd9, 9'd55, 9'd480, 9'd70, 9'd410},
    '{9'd6, 9'd35, 9'd40, 9'd5,  9'd8, 9'd25, 9'd300, 9'd70, 9'd120},
    '{9'd2, 9'd8,  9'd8,  9'd3,  9'd1, 9'd7,  9'd70,  9'd8,  9'd40},
    '{9'd6, 9'd64, 9'd60, 9'd10, 9'd9, 9'd55, 9'd480, 9'd70, 9'd410}
  };

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic       bus_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       presence;
    logic       rejected;
  } result_t;

  function automatic logic [CNT_W-1:0] duration(input logic [1:0] speed, input tm_t k);
    return TIMING[speed][k];
  endfunction

endpackage

[sv/one_wire_bus_master.sv]
// Top level of the one-wire bus master timing engine.
`timescale 1ns / 1ps

// Usage: every input transaction on the item channel is either a tick, one
// microsecond of bus time carrying the sampled line level, or a command
// that starts a bus reset with presence detect, a bit write, a bit read, a
// byte write or a byte read (LSB first). Each accepted transaction yields
// exactly one result transaction on the result channel: the line drive for
// the next microsecond, busy and done flags, read data, presence and a
// rejected flag for commands that arrive while busy or carry an unknown code.
// The speed_mode register (standard, high speed, overdrive) is written via
// speed_we and speed_data; the user must write it only while the block is
// idle, which the block itself does not enforce. Each phase length is taken
// from speed_mode when that phase begins. The result is registered: an
// accepted transaction enters the result register, or the skid register if
// the result is held. Throughput is one transaction per cycle while
// item_stall is low. When the receiver stalls, one further transaction is
// taken into a skid register and only then is item_stall raised, so no
// result is lost. Synchronous reset idles the engine, clears presence, empties
// both result registers and sets speed_mode to SPEED_RESET (standard by default).
module one_wire_bus_master #(
  parameter logic [1:0] SPEED_RESET = owbm_pkg::SPEED_RESET
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  owbm_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output owbm_pkg::result_t result,
  input  logic              speed_we,
  input  logic [1:0]        speed_data
);

  logic [1:0]                 speed_mode;
  owbm_pkg::op_t              operation, operation_next;
  logic [1:0]                 phase, phase_next;
  logic [owbm_pkg::CNT_W-1:0] countdown, countdown_next;
  logic [2:0]                 bit_index, bit_index_next;
  logic [7:0]                 shift_data, shift_data_next;
  logic                       presence_seen, presence_seen_next;
  logic                       done, rejected;
  owbm_pkg::result_t          result_next;
  owbm_pkg::result_t          skid;
  logic                       skid_valid;
  logic                       accept, take;

  // Length of the first phase of a slot for a given operation and data bit.
  function automatic logic [owbm_pkg::CNT_W-1:0] first_len(input logic [1:0] spd,
                                                           input owbm_pkg::op_t op,
                                                           input logic bit0);
    if (op == owbm_pkg::OP_RESET) begin
      return owbm_pkg::duration(spd, owbm_pkg::TM_H);
    end else if (op == owbm_pkg::OP_WRITE_BIT || op == owbm_pkg::OP_WRITE_BYTE) begin
      return bit0 ? owbm_pkg::duration(spd, owbm_pkg::TM_A)
                  : owbm_pkg::duration(spd, owbm_pkg::TM_C);
    end
    return owbm_pkg::duration(spd, owbm_pkg::TM_A);
  endfunction

  assign item_stall = skid_valid;
  assign accept     = item_valid && !skid_valid;
  assign take       = result_valid && !result_stall;

  // Next state and result of one transaction.
  always_comb begin
    logic is_wr, is_wr_next;
    operation_next     = operation;
    phase_next         = phase;
    countdown_next     = countdown;
    bit_index_next     = bit_index;
    shift_data_next    = shift_data;
    presence_seen_next = presence_seen;
    done               = 1'b0;
    rejected           = 1'b0;
    is_wr = (operation == owbm_pkg::OP_WRITE_BIT) || (operation == owbm_pkg::OP_WRITE_BYTE);

    if (item.command == owbm_pkg::CMD_TICK) begin
      if (operation != owbm_pkg::OP_IDLE) begin
        if (countdown > owbm_pkg::CNT_W'(1)) begin
          countdown_next = countdown - owbm_pkg::CNT_W'(1);
        end else if (phase == 2'd0) begin
          // Low phase over: release the line.
          phase_next = 2'd1;
          if (operation == owbm_pkg::OP_RESET) begin
            countdown_next = owbm_pkg::duration(speed_mode, owbm_pkg::TM_I);
          end else if (is_wr) begin
            countdown_next = shift_data[0] ? owbm_pkg::duration(speed_mode, owbm_pkg::TM_B)
                                           : owbm_pkg::duration(speed_mode, owbm_pkg::TM_D);
          end else begin
            countdown_next = owbm_pkg::duration(speed_mode, owbm_pkg::TM_E);
          end
        end else if (phase == 2'd1 && !is_wr) begin
          // End of release on a read or reset: this tick's level is the sample.
          phase_next = 2'd2;
          if (operation == owbm_pkg::OP_RESET) begin
            presence_seen_next = !item.bus_level;
            countdown_next     = owbm_pkg::duration(speed_mode, owbm_pkg::TM_J);
          end else begin
            if (operation == owbm_pkg::OP_READ_BIT) begin
              shift_data_next = {7'd0, item.bus_level};
            end else begin
              shift_data_next = {item.bus_level, shift_data[7:1]};
            end
            countdown_next = owbm_pkg::duration(speed_mode, owbm_pkg::TM_F);
          end
        end else begin
          // Slot finished: next bit of a byte, or the operation ends.
          if (is_wr) begin
            shift_data_next = {1'b0, shift_data[7:1]};
          end
          if ((operation == owbm_pkg::OP_WRITE_BYTE || operation == owbm_pkg::OP_READ_BYTE)
              && bit_index != 3'd7) begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = 2'd0;
            countdown_next = first_len(speed_mode, operation, shift_data_next[0]);
          end else begin
            operation_next = owbm_pkg::OP_IDLE;
            phase_next     = 2'd0;
            countdown_next = '0;
            bit_index_next = '0;
            done           = 1'b1;
          end
        end
      end
    end else if (item.command > owbm_pkg::CMD_READ_BYTE || operation != owbm_pkg::OP_IDLE) begin
      rejected = 1'b1;
    end else begin
      operation_next = owbm_pkg::op_t'(item.command);
      bit_index_next = '0;
      unique case (item.command)
        owbm_pkg::CMD_WRITE_BIT:  shift_data_next = {7'd0, item.write_data[0]};
        owbm_pkg::CMD_WRITE_BYTE: shift_data_next = item.write_data;
        owbm_pkg::CMD_READ_BIT,
        owbm_pkg::CMD_READ_BYTE:  shift_data_next = '0;
        default:                  shift_data_next = shift_data;
      endcase
      if (item.command == owbm_pkg::CMD_RESET) begin
        presence_seen_next = 1'b0;
      end
      phase_next     = 2'd0;
      countdown_next = first_len(speed_mode, operation_next, shift_data_next[0]);
    end

    is_wr_next = (operation_next == owbm_pkg::OP_WRITE_BIT) ||
                 (operation_next == owbm_pkg::OP_WRITE_BYTE);
    result_next.drive_low = (operation_next != owbm_pkg::OP_IDLE) && (phase_next == 2'd0);
    result_next.busy_res  = operation_next != owbm_pkg::OP_IDLE;
    result_next.done_res  = done;
    result_next.read_data = is_wr_next ? 8'd0 : shift_data_next;
    result_next.presence  = presence_seen_next;
    result_next.rejected  = rejected;
  end

  // Engine state and speed register.
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_mode    <= SPEED_RESET;
      operation     <= owbm_pkg::OP_IDLE;
      phase         <= '0;
      countdown     <= '0;
      bit_index     <= '0;
      shift_data    <= '0;
      presence_seen <= 1'b0;
    end else begin
      if (speed_we) begin
        speed_mode <= speed_data;
      end
      if (accept) begin
        operation     <= operation_next;
        phase         <= phase_next;
        countdown     <= countdown_next;
        bit_index     <= bit_index_next;
        shift_data    <= shift_data_next;
        presence_seen <= presence_seen_next;
      end
    end
  end

  // Result register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (!result_valid) begin
      result_valid <= accept;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      result <= skid;
    end else if (accept && (take || !result_valid)) begin
      result <= result_next;
    end
    if (accept && result_valid && !take) begin
      skid <= result_next;
    end
  end

  // The skid stage only fills behind a held result.
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid register full while result register empty");

  // Idle engine carries no leftover slot state.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (operation == owbm_pkg::OP_IDLE) |-> (phase == 2'd0 && countdown == '0 && bit_index == '0))
    else $error("idle engine with leftover phase, countdown or bit index");

  // A running operation always has time left in its phase.
  a_busy_counting: assert property (@(posedge clk) disable iff (rst)
    (operation != owbm_pkg::OP_IDLE) |-> (countdown != '0 && phase != 2'd3))
    else $error("busy engine with empty countdown or bad phase");

  // A rejected command leaves the engine untouched.
  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && rejected) |=> ($stable(operation) && $stable(countdown) && $stable(phase)))
    else $error("rejected command changed engine state");

endmodule
